@@ sv/epva_pkg.sv @@
// Shared types and constants for the encoder position/velocity averager.
// No dependencies.
package epva_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int WINDOW_DEF   = 8;

  localparam int VAL_W     = 48;   // Q32.16 result width
  localparam int REG_W     = 32;   // width of gain/bias registers and input fields
  localparam int CFG_IDX_W = 3;
  localparam int DIVN_W    = 74;   // dividend width: 64-bit product times 1000
  localparam int MUL_STEPS = 33;   // bits of the count-change magnitude
  localparam int DIV_STEPS = DIVN_W;
  localparam int STEP_W    = 7;

  // Register indexes: gains from CFG_GAIN_BASE, biases from CFG_BIAS_BASE
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_BASE = 3'd4;

  localparam logic [VAL_W-1:0] MAX48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] MIN48 = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_PREP,
    ST_DIVV,
    ST_UPD,
    ST_DIVP,
    ST_MID,
    ST_DIVA,
    ST_OUT
  } state_e;

endpackage

@@ sv/encoder_position_velocity_averager_core.sv @@
// Encoder position/velocity averager, bit-serial multiply and restoring divide.
// Depends on epva_pkg.
//
// One item at a time; next input taken the cycle after the result is loaded.
// Built from a 33-step shift-add multiplier and up to three 74-step passes of
// one shared restoring divider (velocity, skipped for a zero interval, and two
// means). Reset (async, active low) loads gains to 1.0; biases, history,
// window sums and valid bits to 0.
module encoder_position_velocity_averager_core #(
  parameter int CHANNELS = epva_pkg::CHANNELS_DEF,
  parameter int WINDOW   = epva_pkg::WINDOW_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream; tdata: channel[1:0], raw_count[33:2], stamp_ms[65:34], zero pad
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,
  // result stream; tdata: out_channel[1:0], avg_position[49:2], avg_velocity[97:50]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o,
  // tuser: velocity_valid[0]
  output logic        m_axis_tuser_o,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [epva_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [epva_pkg::REG_W-1:0]     cfg_wdata_i
);

  localparam int VW    = epva_pkg::VAL_W;
  localparam int RW    = epva_pkg::REG_W;
  localparam int NW    = epva_pkg::DIVN_W;
  localparam int SW_N  = epva_pkg::STEP_W;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SL_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = VW + $clog2(WINDOW);

  localparam logic signed [VW-1:0] MAX48_S = epva_pkg::MAX48;
  localparam logic signed [VW-1:0] MIN48_S = epva_pkg::MIN48;

  epva_pkg::state_e state_q, state_d;

  // configuration registers
  logic [RW-1:0] gain_q [4];
  logic [RW-1:0] bias_q [4];

  // per-channel history and running window sums
  logic [RW-1:0]           last_count_q [CHANNELS];
  logic [RW-1:0]           last_stamp_q [CHANNELS];
  logic [SL_W-1:0]         slot_q       [CHANNELS];
  logic signed [SUM_W-1:0] psum_q       [CHANNELS];
  logic signed [SUM_W-1:0] vsum_q       [CHANNELS];
  logic [DEPTH-1:0]        vbit_q;     // entry written since reset

  // window store: {position, velocity} per entry
  logic [2*VW-1:0] mem_q [DEPTH];
  logic [2*VW-1:0] rd_q;

  // item payload and datapath
  logic [1:0]      ch_q;
  logic [RW-1:0]   count_q, stamp_q, elapsed_q;
  logic [AW-1:0]   addr_q;
  logic [SW_N-1:0] step_q;
  logic [63:0]     mc_q, acc1_q, acc2_q;
  logic [32:0]     mp1_q, mp2_q;
  logic            cneg_q, vneg_q, ezero_q, sneg_q;
  logic signed [VW-1:0]    pos_q;
  logic signed [SUM_W-1:0] nvs_q;
  logic [VW-1:0]   avgp_q;
  logic [RW-1:0]   rem_q, dvs_q;
  logic [NW-1:0]   quo_q;

  // output register
  logic          mvalid_q;
  logic [1:0]    och_q;
  logic [VW-1:0] oavgp_q, oavgv_q;
  logic          ovv_q;

  logic [CH_W-1:0] chi;
  logic [RW-1:0]   gsel, bsel, lc, ls;
  logic [RW-1:0]   gmag, cmag;
  logic [32:0]     delta, dmag;
  logic [65:0]     pfull;
  logic signed [VW-1:0] pos_sat;
  logic [NW-1:0]   prod1000;
  logic [VW-1:0]   vlim, vmag;
  logic signed [VW-1:0] vel;
  logic signed [VW-1:0] oldp, oldv;
  logic signed [SUM_W:0] nps, nvs;
  logic [SUM_W-1:0] nps_t, nvs_t, psmag, vsmag;
  logic [32:0]     rs;
  logic            ge;
  logic [VW-1:0]   qneg;
  logic            in_xfer, out_load, s_ch_ok, step_last_mul, step_last_div;

  assign s_ch_ok  = 32'(s_axis_tdata_i[1:0]) < 32'(CHANNELS);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == epva_pkg::ST_OUT) && (!mvalid_q || m_axis_tready_i);
  assign step_last_mul = step_q == SW_N'(epva_pkg::MUL_STEPS - 1);
  assign step_last_div = step_q == SW_N'(epva_pkg::DIV_STEPS - 1);

  // ---------------------------------------------------------------------------
  // Combinational datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    chi  = CH_W'(ch_q);
    gsel = gain_q[ch_q];
    bsel = bias_q[ch_q];
    lc   = last_count_q[chi];
    ls   = last_stamp_q[chi];
    gmag = gsel[RW-1] ? (~gsel + 1'b1) : gsel;
    cmag = count_q[RW-1] ? (~count_q + 1'b1) : count_q;
    delta = {count_q[RW-1], count_q} - {lc[RW-1], lc};
    dmag  = delta[32] ? (~delta + 1'b1) : delta;

    // position: +/- |count|*|gain| + bias, then clamp to 48 bits
    pfull = (cneg_q ? (~{2'b00, acc1_q} + 66'd1) : {2'b00, acc1_q})
            + {{34{bsel[RW-1]}}, bsel};
    if (!pfull[65] && (|pfull[64:47]))      pos_sat = MAX48_S;
    else if (pfull[65] && !(&pfull[64:47])) pos_sat = MIN48_S;
    else                                    pos_sat = pfull[VW-1:0];

    // x1000 as x1024 - x16 - x8
    prod1000 = ({10'd0, acc2_q} << 10) - ({10'd0, acc2_q} << 4) - ({10'd0, acc2_q} << 3);

    // velocity clamp, magnitude limit depends on sign
    vlim = vneg_q ? epva_pkg::MIN48 : epva_pkg::MAX48;
    vmag = ((|quo_q[NW-1:VW]) || (quo_q[VW-1:0] > vlim)) ? vlim : quo_q[VW-1:0];
    if (ezero_q)     vel = '0;
    else if (vneg_q) vel = ~vmag + 1'b1;
    else             vel = vmag;

    // old window entry, zero if never written
    oldp = vbit_q[addr_q] ? rd_q[2*VW-1:VW] : '0;
    oldv = vbit_q[addr_q] ? rd_q[VW-1:0]    : '0;
    nps  = psum_q[chi] + pos_q - oldp;
    nvs  = vsum_q[chi] + vel - oldv;
    nps_t = nps[SUM_W-1:0];
    nvs_t = nvs[SUM_W-1:0];
    psmag = nps_t[SUM_W-1] ? (~nps_t + 1'b1) : nps_t;
    vsmag = nvs_q[SUM_W-1] ? (~nvs_q + 1'b1) : nvs_q;

    // restoring divide step
    rs = {rem_q, quo_q[NW-1]};
    ge = rs >= {1'b0, dvs_q};

    // signed mean from quotient; magnitude fits 48 bits
    qneg = sneg_q ? (~quo_q[VW-1:0] + 1'b1) : quo_q[VW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      epva_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && s_ch_ok) state_d = epva_pkg::ST_LOAD;
      end
      epva_pkg::ST_LOAD: state_d = epva_pkg::ST_MUL;
      epva_pkg::ST_MUL:  if (step_last_mul) state_d = epva_pkg::ST_PREP;
      epva_pkg::ST_PREP: state_d = (elapsed_q == '0) ? epva_pkg::ST_UPD : epva_pkg::ST_DIVV;
      epva_pkg::ST_DIVV: if (step_last_div) state_d = epva_pkg::ST_UPD;
      epva_pkg::ST_UPD:  state_d = epva_pkg::ST_DIVP;
      epva_pkg::ST_DIVP: if (step_last_div) state_d = epva_pkg::ST_MID;
      epva_pkg::ST_MID:  state_d = epva_pkg::ST_DIVA;
      epva_pkg::ST_DIVA: if (step_last_div) state_d = epva_pkg::ST_OUT;
      epva_pkg::ST_OUT:  if (out_load) state_d = epva_pkg::ST_IDLE;
      default:           state_d = epva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= epva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state with reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        gain_q[i] <= 32'h0001_0000;
        bias_q[i] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        last_count_q[i] <= '0;
        last_stamp_q[i] <= '0;
        slot_q[i]       <= '0;
        psum_q[i]       <= '0;
        vsum_q[i]       <= '0;
      end
      vbit_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i >= epva_pkg::CFG_BIAS_BASE) bias_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
        else                                      gain_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      end
      if (state_q == epva_pkg::ST_UPD) begin
        last_count_q[chi] <= count_q;
        last_stamp_q[chi] <= stamp_q;
        slot_q[chi] <= (slot_q[chi] == SL_W'(WINDOW - 1)) ? '0 : slot_q[chi] + 1'b1;
        psum_q[chi] <= nps_t;
        vsum_q[chi] <= nvs_t;
        vbit_q[addr_q] <= 1'b1;
      end
      if (out_load)             mvalid_q <= 1'b1;
      else if (m_axis_tready_i) mvalid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers and window store
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr_q];
    if (state_q == epva_pkg::ST_UPD) mem_q[addr_q] <= {pos_q, vel};

    unique case (state_q)
      epva_pkg::ST_IDLE: begin
        if (in_xfer) begin
          ch_q    <= s_axis_tdata_i[1:0];
          count_q <= s_axis_tdata_i[33:2];
          stamp_q <= s_axis_tdata_i[65:34];
        end
      end
      epva_pkg::ST_LOAD: begin
        addr_q    <= AW'(chi) * AW'(WINDOW) + AW'(slot_q[chi]);
        elapsed_q <= stamp_q - ls;
        mc_q      <= {32'd0, gmag};
        mp1_q     <= {1'b0, cmag};
        mp2_q     <= dmag;
        acc1_q    <= '0;
        acc2_q    <= '0;
        cneg_q    <= count_q[RW-1] ^ gsel[RW-1];
        vneg_q    <= delta[32] ^ gsel[RW-1];
        step_q    <= '0;
      end
      epva_pkg::ST_MUL: begin
        // one multiplier bit per cycle for both products
        if (mp1_q[0]) acc1_q <= acc1_q + mc_q;
        if (mp2_q[0]) acc2_q <= acc2_q + mc_q;
        mc_q   <= mc_q << 1;
        mp1_q  <= mp1_q >> 1;
        mp2_q  <= mp2_q >> 1;
        step_q <= step_last_mul ? '0 : step_q + 1'b1;
      end
      epva_pkg::ST_PREP: begin
        pos_q   <= pos_sat;
        ezero_q <= elapsed_q == '0;
        quo_q   <= prod1000;
        rem_q   <= '0;
        dvs_q   <= elapsed_q;
      end
      epva_pkg::ST_DIVV, epva_pkg::ST_DIVP, epva_pkg::ST_DIVA: begin
        rem_q  <= ge ? 32'(rs - {1'b0, dvs_q}) : rs[RW-1:0];
        quo_q  <= {quo_q[NW-2:0], ge};
        step_q <= step_last_div ? '0 : step_q + 1'b1;
      end
      epva_pkg::ST_UPD: begin
        nvs_q  <= nvs_t;
        sneg_q <= nps_t[SUM_W-1];
        quo_q  <= NW'(psmag);
        rem_q  <= '0;
        dvs_q  <= RW'(WINDOW);
        step_q <= '0;
      end
      epva_pkg::ST_MID: begin
        avgp_q <= qneg;
        sneg_q <= nvs_q[SUM_W-1];
        quo_q  <= NW'(vsmag);
        rem_q  <= '0;
      end
      epva_pkg::ST_OUT: begin
        if (out_load) begin
          och_q   <= ch_q;
          oavgp_q <= avgp_q;
          oavgv_q <= qneg;
          ovv_q   <= !ezero_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {6'd0, oavgv_q, oavgp_q, och_q};
  assign m_axis_tuser_o  = ovv_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == epva_pkg::ST_DIVP || state_q == epva_pkg::ST_DIVA ||
     state_q == epva_pkg::ST_DIVV) |-> rem_q < dvs_q)
    else $error("divider remainder not below divisor");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_ch_ok) |=> !s_axis_tready_o)
    else $error("input taken while item in flight");

  // step counter only meaningful while a multiply or divide pass runs
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == epva_pkg::ST_MUL || state_q == epva_pkg::ST_DIVV ||
     state_q == epva_pkg::ST_DIVP || state_q == epva_pkg::ST_DIVA) |->
    step_q <= SW_N'(epva_pkg::DIV_STEPS - 1))
    else $error("step counter overran");

endmodule
